>>> hdl/xkb64_pkg.sv
`default_nettype none

package xkb64_pkg;

   // largest usable key
   localparam int unsigned MAX_KEY_BYTES = 16;

   // configuration port geometry
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 64;

   // register indexes
   localparam logic [1:0] REG_ENABLE     = 2'd0;
   localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
   localparam logic [1:0] REG_KEY_LOW    = 2'd2;
   localparam logic [1:0] REG_KEY_HIGH   = 2'd3;

   // item modes
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       mode;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       carries_byte;
      logic       out_last;
   } rsp_item_type;

   typedef struct packed {
      logic        enable;
      logic [4:0]  key_length;
      logic [63:0] key_bytes_low;
      logic [63:0] key_bytes_high;
   } cfg_type;

   // all results caused by one input transaction
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_slot;
      logic            carries_byte;
      logic            out_last;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // 6-bit value to alphabet character
   function automatic logic [7:0] encode_char(input logic [5:0] v);
      logic [7:0] r;
      case (v) inside
         [6'd0:6'd25]:  r = CHAR_UPPER_A + {2'b00, v};
         [6'd26:6'd51]: r = CHAR_LOWER_A + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: r = CHAR_DIGIT_0 + {2'b00, v} - 8'd52;
         6'd62:         r = CHAR_PLUS;
         default:       r = CHAR_SLASH;
      endcase
      return r;
   endfunction

   // alphabet character to 6-bit value, invalid characters flagged
   function automatic sextet_type decode_char(input logic [7:0] c);
      sextet_type r;
      r.valid = 1'b1;
      case (c) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: r.value = 6'(c - CHAR_UPPER_A);
         [CHAR_LOWER_A:CHAR_LOWER_Z]: r.value = 6'(c - CHAR_LOWER_A + 8'd26);
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: r.value = 6'(c - CHAR_DIGIT_0 + 8'd52);
         CHAR_PLUS:                   r.value = 6'd62;
         CHAR_SLASH:                  r.value = 6'd63;
         default: begin
            r.valid = 1'b0;
            r.value = 6'd0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/xkb64_csr.sv
`default_nettype none

module xkb64_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [xkb64_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [xkb64_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [xkb64_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                       csr_pready,
   output xkb64_pkg::cfg_type                         cfg
);
   import xkb64_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[4:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_ENABLE:     cfg_in.enable         = csr_pwdata[0];
            REG_KEY_LENGTH: cfg_in.key_length     = csr_pwdata[4:0];
            REG_KEY_LOW:    cfg_in.key_bytes_low  = csr_pwdata;
            REG_KEY_HIGH:   cfg_in.key_bytes_high = csr_pwdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      case (reg_index)
         REG_ENABLE:     csr_prdata = {63'd0, cfg_ff.enable};
         REG_KEY_LENGTH: csr_prdata = {59'd0, cfg_ff.key_length};
         REG_KEY_LOW:    csr_prdata = cfg_ff.key_bytes_low;
         REG_KEY_HIGH:   csr_prdata = cfg_ff.key_bytes_high;
         default:        csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/xkb64_front.sv
`default_nettype none

module xkb64_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire xkb64_pkg::cfg_type        cfg,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire xkb64_pkg::req_item_type   req_data,
   input  wire logic                      queue_full,
   output logic                           push,
   output xkb64_pkg::bundle_type          push_data
);
   import xkb64_pkg::*;

   logic [11:0] acc_ff, acc_in;
   logic [3:0]  pend_ff, pend_in;
   logic [3:0]  kpos_ff, kpos_in;
   logic [1:0]  cmf_ff, cmf_in;
   logic        pad_ff, pad_in;

   logic        req_fire;
   logic [4:0]  key_len;
   logic [3:0]  kp0;
   logic [4:0]  kp_inc;
   logic [3:0]  kpos_after;
   logic [127:0] key_all;
   logic [7:0]  key_byte;
   logic [7:0]  key_src;
   logic [7:0]  keyed;

   // encrypt path
   logic [11:0] e_acc;
   logic [3:0]  e_p;
   logic [11:0] e_acc_new;
   logic [3:0]  e_sh0;
   logic [11:0] e_shr;
   logic        e_two;
   logic [3:0]  e_p3;
   logic [11:0] e_shl;
   logic [5:0]  e_c0, e_c1, e_tail;
   logic        e_nt;
   logic [1:0]  e_nm;
   logic [1:0]  e_cmf1;
   logic [1:0]  e_pads;
   logic [2:0]  e_total;

   // decrypt path
   logic [11:0] d_acc;
   logic [3:0]  d_p;
   sextet_type  d_dec;
   logic        d_is_pad;
   logic        d_take;
   logic [11:0] d_acc_new;
   logic [3:0]  d_p1;
   logic [3:0]  d_sh;
   logic [11:0] d_shr;
   logic [7:0]  d_byte;
   logic        d_produced;

   assign req_ready = ~queue_full;
   assign req_fire  = req_valid & req_ready;

   // key byte selection and position advance
   always_comb begin
      key_len    = (cfg.key_length > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : cfg.key_length;
      kp0        = ({1'b0, kpos_ff} >= key_len) ? 4'd0 : kpos_ff;
      kp_inc     = {1'b0, kp0} + 5'd1;
      kpos_after = (key_len == 5'd0) ? kpos_ff
                 : (kp_inc >= key_len) ? 4'd0 : kp_inc[3:0];
      key_all    = {cfg.key_bytes_high, cfg.key_bytes_low};
      key_byte   = key_all[{kp0, 3'b000} +: 8];
      key_src    = (req_data.mode == MODE_DECRYPT) ? d_byte : req_data.in_byte;
      keyed      = (key_len == 5'd0) ? key_src : (key_src ^ key_byte);
   end

   // encrypt: append a byte, emit one or two characters, pad at message end
   always_comb begin
      e_acc     = (pend_ff > 4'd4) ? 12'd0 : acc_ff;
      e_p       = (pend_ff > 4'd4) ? 4'd0 : pend_ff;
      e_acc_new = {e_acc[3:0], keyed};
      e_sh0     = e_p + 4'd2;
      e_shr     = e_acc_new >> e_sh0;
      e_c0      = e_shr[5:0];
      e_c1      = e_acc_new[5:0];
      e_two     = (e_sh0 >= 4'd6);
      e_p3      = e_two ? 4'd0 : e_sh0;
      e_shl     = e_acc_new << (4'd6 - e_p3);
      e_tail    = e_shl[5:0];
      e_nm      = e_two ? 2'd2 : 2'd1;
      e_nt      = req_data.in_last & (e_p3 != 4'd0);
      e_cmf1    = cmf_ff + e_nm + {1'b0, e_nt};
      e_pads    = req_data.in_last ? 2'(2'd0 - e_cmf1) : 2'd0;
      e_total   = {1'b0, e_nm} + {2'b00, e_nt} + {1'b0, e_pads};
   end

   // decrypt: skip invalid characters, stop at pad, emit a byte per eight bits
   always_comb begin
      d_acc      = (pend_ff > 4'd6) ? 12'd0 : acc_ff;
      d_p        = (pend_ff > 4'd6) ? 4'd0 : pend_ff;
      d_dec      = decode_char(req_data.in_byte);
      d_is_pad   = (req_data.in_byte == CHAR_PAD);
      d_take     = ~pad_ff & ~d_is_pad & d_dec.valid;
      d_acc_new  = {d_acc[5:0], d_dec.value};
      d_p1       = d_p + 4'd6;
      d_sh       = d_p1 - 4'd8;
      d_shr      = d_acc_new >> d_sh;
      d_byte     = d_shr[7:0];
      d_produced = d_take & (d_p1 >= 4'd8);
   end

   // result bundle and next state
   always_comb begin
      acc_in  = acc_ff;
      pend_in = pend_ff;
      kpos_in = kpos_ff;
      cmf_in  = cmf_ff;
      pad_in  = pad_ff;

      push_data              = '0;
      push_data.carries_byte = 1'b1;
      push_data.out_last     = req_data.in_last;
      push                   = 1'b0;

      if (!cfg.enable) begin
         push_data.bytes[0] = req_data.in_byte;
         push               = req_fire;
      end else if (req_data.mode == MODE_ENCRYPT) begin
         push_data.bytes[0]  = encode_char(e_c0);
         push_data.bytes[1]  = e_two ? encode_char(e_c1)
                             : e_nt ? encode_char(e_tail) : CHAR_PAD;
         push_data.bytes[2]  = (e_two & e_nt) ? encode_char(e_tail) : CHAR_PAD;
         push_data.bytes[3]  = CHAR_PAD;
         push_data.last_slot = (e_total > 3'd4) ? 2'd3 : 2'(e_total - 3'd1);
         push                = req_fire;
         acc_in  = e_acc_new;
         pend_in = e_p3;
         kpos_in = kpos_after;
         cmf_in  = cmf_ff + e_nm;
      end else begin
         push_data.bytes[0]     = d_produced ? keyed : 8'd0;
         push_data.carries_byte = d_produced;
         push                   = req_fire & (d_produced | req_data.in_last);
         acc_in  = d_take ? d_acc_new : d_acc;
         pend_in = d_take ? (d_produced ? d_sh : d_p1) : d_p;
         kpos_in = d_produced ? kpos_after : kpos_ff;
         pad_in  = pad_ff | d_is_pad;
      end

      // message end clears everything
      if (req_data.in_last) begin
         acc_in  = '0;
         pend_in = '0;
         kpos_in = '0;
         cmf_in  = '0;
         pad_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
         kpos_ff <= '0;
         cmf_ff  <= '0;
         pad_ff  <= 1'b0;
      end else if (req_fire) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         kpos_ff <= kpos_in;
         cmf_ff  <= cmf_in;
         pad_ff  <= pad_in;
      end
   end

   // bit count stays even and within one sextet plus spare
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff <= 4'd6) && !pend_ff[0])
      else $error("pending bit count out of range");

   // a message end leaves clean state behind
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.in_last |=>
         (pend_ff == 4'd0) && (kpos_ff == 4'd0) && (cmf_ff == 2'd0) && !pad_ff)
      else $error("state not cleared after message end");

endmodule

`default_nettype wire

>>> hdl/xkb64_queue.sv
`default_nettype none

module xkb64_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire xkb64_pkg::bundle_type push_data,
   output logic                       full,
   input  wire logic                  pop,
   output xkb64_pkg::bundle_type      head_data,
   output logic                       empty
);
   import xkb64_pkg::*;

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

   bundle_type            entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign head_data = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill count above depth");

   assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

endmodule

`default_nettype wire

>>> hdl/xkb64_back.sv
`default_nettype none

module xkb64_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire xkb64_pkg::bundle_type head_data,
   input  wire logic                  empty,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output xkb64_pkg::rsp_item_type    rsp_data
);
   import xkb64_pkg::*;

   logic [1:0]   slot_ff, slot_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   logic         load;
   logic         at_end;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one result per cycle out of the head bundle while the output register is free or rsp_ready is high
   always_comb begin
      load   = ~empty & (~rsp_valid_ff | rsp_ready);
      at_end = (slot_ff == head_data.last_slot);
      pop    = load & at_end;

      slot_in = slot_ff;
      if (load) begin
         slot_in = at_end ? 2'd0 : slot_ff + 2'd1;
      end

      rsp_data_in              = rsp_data_ff;
      rsp_data_in.out_byte     = head_data.bytes[slot_ff];
      rsp_data_in.carries_byte = head_data.carries_byte;
      rsp_data_in.out_last     = head_data.out_last & at_end;

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // an end-only marker always closes a message
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.carries_byte |-> rsp_data_ff.out_last)
      else $error("marker transaction without end flag");

endmodule

`default_nettype wire

>>> hdl/xor_key_base64_codec.sv
// repeating-key xor with base64, streaming codec
//
// req channel (valid/ready): one transaction per message byte (encrypt) or
// base64 character (decrypt), with mode and in_last. rsp channel (valid/ready):
// result bytes, carries_byte low only on an end-only marker, out_last on the
// final result of a message. csr port: APB-style, 64-bit data, registers at
// 0x00 enable, 0x08 key_length, 0x10 key bytes 0-7, 0x18 key bytes 8-15;
// write only while no transaction is in flight.
//
// a request's result bundle is pushed into the result queue as the request is
// accepted; the back then loads it into the output register behind rsp_valid.
// the front takes one request per cycle while req_ready is high; the back delivers
// one result per cycle while rsp_ready allows, so encrypt yields 4 characters
// per 3 bytes, plus padding at message end, and decrypt at most one byte per
// character. the result queue (QUEUE_DEPTH bundles) lets the front keep
// accepting while the output register waits on rsp_ready; when it fills,
// req_ready drops. reset clears configuration, codec state and the queue.
`default_nettype none

module xor_key_base64_codec #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire xkb64_pkg::req_item_type               req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output xkb64_pkg::rsp_item_type                    rsp_data,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [xkb64_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [xkb64_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [xkb64_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                       csr_pready
);
   import xkb64_pkg::*;

   cfg_type    cfg;
   logic       queue_full;
   logic       queue_empty;
   logic       push;
   logic       pop;
   bundle_type push_data;
   bundle_type head_data;

   // configuration registers
   xkb64_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // accept and compute result bundles
   xkb64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // bundle queue between front and back
   xkb64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (queue_empty)
   );

   // serialize bundles onto the result channel
   xkb64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
   import xkb64_pkg::*;

   localparam int TOTAL_ITEMS      = 410;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 10;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int MISMATCH_REPORTS = 10;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_PERIODIC} stall_style_type;

   // clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   // mirrored configuration
   logic        cfg_enable = 1'b0;
   logic [4:0]  cfg_key_length = '0;
   logic [63:0] cfg_key_low = '0;
   logic [63:0] cfg_key_high = '0;

   // mirrored codec state
   logic [11:0] acc_bits = '0;
   logic [3:0]  acc_count = '0;
   logic [3:0]  key_pos = '0;
   logic [1:0]  char_phase = '0;
   logic        pad_found = 1'b0;

   string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   rsp_item_type expected_results[$];
   int mismatch_count = 0;
   int items_sent = 0;
   int cycle_count = 0;

   // sender burst control
   logic gaps_enabled = 1'b1;
   int burst_left = 0;

   // receiver stall control
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int style_left = 0;
   int pattern_step = 0;
   stall_style_type ready_style = STALL_NONE;

   xor_key_base64_codec dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("xor_key_base64_codec test failed");
         $finish;
      end
   end

   function automatic req_item_type pack_request(input logic [7:0] b, input logic mode,
                                                 input logic last);
      req_item_type r;
      r.in_byte = b;
      r.mode    = mode;
      r.in_last = last;
      return r;
   endfunction

   function automatic rsp_item_type pack_result(input logic [7:0] b, input logic carries,
                                                input logic last);
      rsp_item_type r;
      r.out_byte     = b;
      r.carries_byte = carries;
      r.out_last     = last;
      return r;
   endfunction

   // queue one expected result transaction
   function automatic void add_expected(input rsp_item_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void clear_codec_state();
      acc_bits   = '0;
      acc_count  = '0;
      key_pos    = '0;
      char_phase = '0;
      pad_found  = 1'b0;
   endfunction

   // next key byte applied to b, key position advanced
   function automatic logic [7:0] key_stream_xor(input logic [7:0] b);
      int len;
      int pos;
      logic [7:0] kb;
      len = (cfg_key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(cfg_key_length);
      if (len == 0) return b;
      pos = key_pos;
      if (pos >= len) pos = 0;
      kb = (pos < 8) ? cfg_key_low[8*pos +: 8] : cfg_key_high[8*(pos-8) +: 8];
      pos++;
      if (pos >= len) pos = 0;
      key_pos = 4'(pos);
      return b ^ kb;
   endfunction

   // base64 digit value, -1 outside the alphabet
   function automatic int sextet_of(input logic [7:0] c);
      for (int i = 0; i < 64; i++)
         if (b64_chars[i] == c) return i;
      return -1;
   endfunction

   // expected results of one accepted transaction
   function automatic void codec_predict(input req_item_type item);
      rsp_item_type batch[$];
      logic [7:0] x;
      int v;
      if (!cfg_enable) begin
         add_expected(pack_result(item.in_byte, 1'b1, item.in_last));
         if (item.in_last) clear_codec_state();
         return;
      end
      if (item.mode == MODE_ENCRYPT) begin
         x = key_stream_xor(item.in_byte);
         if (acc_count > 4) begin
            acc_count = '0;
            acc_bits  = '0;
         end
         acc_bits  = {acc_bits[3:0], x};
         acc_count = acc_count + 4'd8;
         while (acc_count >= 6 && batch.size() < 4) begin
            v = int'(acc_bits >> (acc_count - 4'd6)) & 63;
            batch.insert(batch.size(), pack_result(b64_chars[v], 1'b1, 1'b0));
            char_phase++;
            acc_count = acc_count - 4'd6;
         end
         if (item.in_last) begin
            // zero-filled final character, then padding to a group of four
            if (acc_count > 0 && batch.size() < 4) begin
               v = int'(acc_bits << (4'd6 - acc_count)) & 63;
               batch.insert(batch.size(), pack_result(b64_chars[v], 1'b1, 1'b0));
               char_phase++;
            end
            while (char_phase != 0 && batch.size() < 4) begin
               batch.insert(batch.size(), pack_result(CHAR_PAD, 1'b1, 1'b0));
               char_phase++;
            end
            batch[batch.size()-1].out_last = 1'b1;
            clear_codec_state();
         end
      end else begin
         if (acc_count > 6) begin
            acc_count = '0;
            acc_bits  = '0;
         end
         if (!pad_found) begin
            if (item.in_byte == CHAR_PAD) begin
               pad_found = 1'b1;
            end else begin
               v = sextet_of(item.in_byte);
               if (v >= 0) begin
                  acc_bits  = {acc_bits[5:0], v[5:0]};
                  acc_count = acc_count + 4'd6;
                  if (acc_count >= 8) begin
                     x = 8'(acc_bits >> (acc_count - 4'd8));
                     acc_count = acc_count - 4'd8;
                     batch.insert(batch.size(), pack_result(key_stream_xor(x), 1'b1, 1'b0));
                  end
               end
            end
         end
         if (item.in_last) begin
            // nothing decoded: end-only marker
            if (batch.size() == 0) batch.insert(0, pack_result(8'h00, 1'b0, 1'b1));
            else batch[batch.size()-1].out_last = 1'b1;
            clear_codec_state();
         end
      end
      foreach (batch[i]) add_expected(batch[i]);
   endfunction

   // one request transaction, then a random gap at the end of a burst when gaps are enabled
   task automatic send_item(input req_item_type item);
      int gap;
      @(negedge clock);
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      codec_predict(item);
      items_sent++;
      if (gaps_enabled) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic send_text(input logic mode, input string text);
      for (int i = 0; i < text.len(); i++)
         send_item(pack_request(text[i], mode, i == text.len() - 1));
   endtask

   // stop sending and let every expected result come out
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // apb write: setup then access phase
   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_ENABLE:     cfg_enable = value[0];
         REG_KEY_LENGTH: cfg_key_length = value[4:0];
         REG_KEY_LOW:    cfg_key_low = value;
         REG_KEY_HIGH:   cfg_key_high = value;
         default:        ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_config(input logic en, input logic [4:0] len, input logic [63:0] lo,
                             input logic [63:0] hi);
      wait_for_drain();
      write_reg(REG_ENABLE, {63'd0, en});
      write_reg(REG_KEY_LENGTH, {59'd0, len});
      write_reg(REG_KEY_LOW, lo);
      write_reg(REG_KEY_HIGH, hi);
   endtask

   // bypass while disabled after reset
   task automatic test_passthrough();
      send_item(pack_request(8'h00, MODE_ENCRYPT, 1'b0));
      send_item(pack_request(8'hFF, MODE_DECRYPT, 1'b1));
      send_item(pack_request(8'h5A, MODE_ENCRYPT, 1'b1));
   endtask

   // plain base64 encode with one, two and zero pad characters
   task automatic test_encode_plain();
      set_config(1'b1, 5'd0, '0, '0);
      send_text(MODE_ENCRYPT, "Man");
      send_text(MODE_ENCRYPT, "M");
      send_text(MODE_ENCRYPT, "Ma");
   endtask

   // decode with a skipped character, pad then trailing junk, end-only marker
   task automatic test_decode_plain();
      send_text(MODE_DECRYPT, "TW*Fu");
      send_text(MODE_DECRYPT, "TQ=x");
      send_item(pack_request(8'hFF, MODE_DECRYPT, 1'b1));
   endtask

   // xor with a short key in both directions
   task automatic test_keyed();
      set_config(1'b1, 5'd3, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      send_item(pack_request(8'hFF, MODE_ENCRYPT, 1'b0));
      send_item(pack_request(8'h00, MODE_ENCRYPT, 1'b1));
      send_text(MODE_DECRYPT, "AAA");
   endtask

   // key shortened mid-message, position wraps
   task automatic test_key_change();
      set_config(1'b1, 5'd8, {$urandom, $urandom}, {$urandom, $urandom});
      send_item(pack_request(8'h3C, MODE_ENCRYPT, 1'b0));
      send_item(pack_request(8'hC3, MODE_ENCRYPT, 1'b0));
      wait_for_drain();
      write_reg(REG_KEY_LENGTH, 64'd2);
      send_item(pack_request(8'h81, MODE_ENCRYPT, 1'b1));
   endtask

   // encrypt leftover bits reused by decrypt
   task automatic test_mode_switch();
      send_item(pack_request(8'hC3, MODE_ENCRYPT, 1'b0));
      send_text(MODE_DECRYPT, "AB");
   endtask

   task automatic send_encode_message();
      int len;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
         send_item(pack_request(8'($urandom), MODE_ENCRYPT, i == len - 1));
   endtask

   task automatic send_decode_message();
      int nchars;
      int npad;
      logic [7:0] c;
      nchars = $urandom_range(1, 16);
      npad = $urandom_range(0, 2);
      for (int i = 0; i < nchars + npad; i++) begin
         if (i >= nchars) c = CHAR_PAD;
         else if ($urandom_range(0, 9) == 0) c = 8'($urandom);
         else c = b64_chars[$urandom_range(0, 63)];
         send_item(pack_request(c, MODE_DECRYPT, i == nchars + npad - 1));
      end
   endtask

   // broken sequences: any byte, mixed modes, end marker rarely
   task automatic send_noise();
      int len;
      len = $urandom_range(1, 8);
      repeat (len)
         send_item(pack_request(8'($urandom), 1'($urandom), $urandom_range(0, 5) == 0));
   endtask

   // receiver holds off while the sender keeps offering transactions
   task automatic test_receiver_holdoff();
      set_config(1'b1, 5'd16, {$urandom, $urandom}, {$urandom, $urandom});
      gaps_enabled = 1'b0;
      hold_requests++;
      for (int i = 0; i < 40; i++)
         send_item(pack_request(8'($urandom), MODE_ENCRYPT, i % 8 == 7));
      wait_for_drain();
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [4:0] len;
      logic [63:0] keys[2];
      int kind;
      while (items_sent < TOTAL_ITEMS) begin
         // new setting, extremes included
         case ($urandom_range(0, 5))
            0:       len = 5'd0;
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 15));
         endcase
         foreach (keys[k]) begin
            case ($urandom_range(0, 3))
               0:       keys[k] = '0;
               1:       keys[k] = '1;
               default: keys[k] = {$urandom, $urandom};
            endcase
         end
         set_config($urandom_range(0, 4) != 0, len, keys[0], keys[1]);
         gaps_enabled = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 5)) begin
            if (items_sent >= TOTAL_ITEMS) break;
            kind = $urandom_range(0, 9);
            if (kind < 4) send_encode_message();
            else if (kind < 8) send_decode_message();
            else send_noise();
         end
      end
      wait_for_drain();
   endtask

   // receiver stall pattern, with the long hold-off on request
   always @(negedge clock) begin : rsp_pattern
      logic ready_next;
      if (style_left == 0) begin
         ready_style = stall_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(20, 120);
      end else begin
         style_left--;
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      pattern_step++;
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else begin
         case (ready_style)
            STALL_NONE:   ready_next = 1'b1;
            STALL_COIN:   ready_next = 1'($urandom_range(0, 1));
            STALL_SPARSE: ready_next = ($urandom_range(0, 7) != 0);
            default:      ready_next = (pattern_step % 5) < 3;
         endcase
      end
      rsp_ready <= ready_next;
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS)
               $display("unexpected result at %0t: byte %02h carries %0b last %0b",
                        $time, rsp_data.out_byte, rsp_data.carries_byte, rsp_data.out_last);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.carries_byte !== want.carries_byte ||
                rsp_data.out_last !== want.out_last) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_REPORTS)
                  $display("mismatch at %0t: expected %02h/%0b/%0b got %02h/%0b/%0b",
                           $time, want.out_byte, want.carries_byte, want.out_last,
                           rsp_data.out_byte, rsp_data.carries_byte, rsp_data.out_last);
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_passthrough();
      test_encode_plain();
      test_decode_plain();
      test_keyed();
      test_key_change();
      test_mode_switch();
      test_receiver_holdoff();
      test_random_traffic();
      wait_for_drain();
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("xor_key_base64_codec test passed");
      else
         $display("xor_key_base64_codec test failed");
      $finish;
   end

endmodule

`default_nettype wire
